/* sv/glit_pkg.sv */
package glit_pkg;

    localparam int CMD_W  = 3;
    localparam int CHAR_W = 8;
    localparam int OFS_W  = 13;
    localparam int LINE_W = 8;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MOVE      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOCATE    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SPAN      = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE = 8'd10;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] char_value;
        logic [OFS_W-1:0]  count;
        logic [OFS_W-1:0]  text_offset;
        logic [LINE_W-1:0] line_index;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [LINE_W-1:0] line_number;
        logic [OFS_W-1:0]  column;
        logic [OFS_W-1:0]  span_start;
        logic [OFS_W-1:0]  span_end;
        logic [OFS_W-1:0]  text_length;
    } t_res;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_START,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SCAN_END,
        S_COPY_RD,
        S_COPY_WR,
        S_NL_WR,
        S_BS_RD,
        S_BS_CMP,
        S_COL_CMP,
        S_SPAN_A,
        S_SPAN_B,
        S_DONE
    } t_state;

endpackage

/* sv/glit_chan_if.sv */
interface glit_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/glit_ram.sv */
module glit_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* sv/glit_alu.sv */
module glit_alu #(
    parameter int W = 13
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic         i_sub,
    output logic [W-1:0] o_res,
    output logic         o_borrow
);
    logic [W:0] t;

    always_comb begin
        if (i_sub) begin
            t = {1'b0, i_a} - {1'b0, i_b};
        end else begin
            t = {1'b0, i_a} + {1'b0, i_b};
        end
        o_res    = t[W-1:0];
        o_borrow = i_sub & t[W];
    end
endmodule

/* sv/gap_buffer_text_line_index_unit.sv */
// Channel   Dir   Payload              Handshake
// i_cmd     in    glit_pkg::t_cmd      valid/ready
// o_res     out   glit_pkg::t_res      valid/ready
//
// Insert and delete walk the line-table entries after the cursor line; move and offset
// queries binary-search the line starts, and a span query reads one or two entries.
// The line table sits in one RAM with a single read and a single write port.
// After reset the init state writes entry zero of the table before the first beat is taken.
// A finished result waits in the output register; the next beat is taken meanwhile.
module gap_buffer_text_line_index_unit #(
    parameter int TEXT_CAP = 4096,
    parameter int LINE_CAP = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    glit_chan_if.sink   i_cmd,
    glit_chan_if.source o_res
);
    localparam int TW = $clog2(TEXT_CAP + 1);
    localparam int OW = (TW > glit_pkg::OFS_W) ? TW : glit_pkg::OFS_W;
    localparam int LW = $clog2(LINE_CAP);
    localparam int NW = $clog2(LINE_CAP + 1);
    localparam int IW = (NW > glit_pkg::LINE_W) ? NW : glit_pkg::LINE_W;

    glit_pkg::t_state r_state, n_state;
    glit_pkg::t_cmd   r_cmd, n_cmd;
    logic [OW-1:0] r_cur, n_cur, r_len, n_len, r_dlt, n_dlt, r_ref, n_ref;
    logic [OW-1:0] r_col, n_col, r_ss, n_ss, r_se, n_se;
    logic [NW-1:0] r_nl, n_nl, r_i, n_i, r_end, n_end, r_del, n_del, r_lo, n_lo, r_hi, n_hi;
    logic [LW-1:0] r_cl, n_cl, r_line, n_line;
    logic          r_found, n_found, r_desc, n_desc, r_add, n_add;
    logic [glit_pkg::STAT_W-1:0] r_st, n_st;
    glit_pkg::t_res r_out, n_out;
    logic r_ovalid, n_ovalid;

    logic          ram_we;
    logic [LW-1:0] ram_waddr, ram_raddr;
    logic [OW-1:0] ram_wdata, ram_rdata;
    logic [OW-1:0] alu_a, alu_b, alu_res;
    logic          alu_sub, alu_borrow;

    logic [OW-1:0] cnt_x, off_x, suf, clip;
    logic [IW-1:0] li_x, nl_x;
    logic [NW-1:0] cl_x, mid;

    glit_ram #(.WIDTH(OW), .DEPTH(LINE_CAP)) u_lines (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    glit_alu #(.W(OW)) u_alu (
        .i_a      (alu_a),
        .i_b      (alu_b),
        .i_sub    (alu_sub),
        .o_res    (alu_res),
        .o_borrow (alu_borrow)
    );

    assign i_cmd.ready = (r_state == glit_pkg::S_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= glit_pkg::S_INIT;
            r_cur    <= '0;
            r_len    <= '0;
            r_nl     <= NW'(1);
            r_cl     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_len    <= n_len;
            r_nl     <= n_nl;
            r_cl     <= n_cl;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_dlt   <= n_dlt;
        r_ref   <= n_ref;
        r_col   <= n_col;
        r_ss    <= n_ss;
        r_se    <= n_se;
        r_i     <= n_i;
        r_end   <= n_end;
        r_del   <= n_del;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_line  <= n_line;
        r_found <= n_found;
        r_desc  <= n_desc;
        r_add   <= n_add;
        r_st    <= n_st;
        r_out   <= n_out;
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_cur    = r_cur;
        n_len    = r_len;
        n_dlt    = r_dlt;
        n_ref    = r_ref;
        n_col    = r_col;
        n_ss     = r_ss;
        n_se     = r_se;
        n_nl     = r_nl;
        n_i      = r_i;
        n_end    = r_end;
        n_del    = r_del;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_cl     = r_cl;
        n_line   = r_line;
        n_found  = r_found;
        n_desc   = r_desc;
        n_add    = r_add;
        n_st     = r_st;
        n_out    = r_out;
        n_ovalid = r_ovalid;

        ram_we    = 1'b0;
        ram_waddr = r_i[LW-1:0];
        ram_wdata = alu_res;
        ram_raddr = r_i[LW-1:0];
        alu_a     = ram_rdata;
        alu_b     = r_dlt;
        alu_sub   = !r_add;

        cnt_x = OW'(r_cmd.count);
        off_x = OW'(r_cmd.text_offset);
        suf   = r_len - r_cur;
        clip  = '0;
        li_x  = IW'(r_cmd.line_index);
        nl_x  = IW'(r_nl);
        cl_x  = NW'(r_cl);
        mid   = r_lo + ((r_hi - r_lo) >> 1);

        if (o_res.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            glit_pkg::S_INIT: begin
                // Entry zero always holds offset zero.
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '0;
                n_state   = glit_pkg::S_IDLE;
            end
            glit_pkg::S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd   = i_cmd.data;
                    n_st    = glit_pkg::ST_OK;
                    n_col   = '0;
                    n_ss    = '0;
                    n_se    = '0;
                    n_found = 1'b0;
                    n_state = glit_pkg::S_START;
                end
            end
            glit_pkg::S_START: begin
                n_del  = '0;
                n_desc = 1'b0;
                n_add  = 1'b0;
                priority case (r_cmd.cmd)
                    glit_pkg::CMD_INSERT: begin
                        if (r_len >= OW'(TEXT_CAP) ||
                            (r_cmd.char_value == glit_pkg::NEWLINE &&
                             r_nl >= NW'(LINE_CAP))) begin
                            n_st    = glit_pkg::ST_FULL;
                            n_state = glit_pkg::S_DONE;
                        end else begin
                            n_cur   = r_cur + OW'(1);
                            n_len   = r_len + OW'(1);
                            n_dlt   = OW'(1);
                            n_add   = 1'b1;
                            n_state = glit_pkg::S_COPY_RD;
                            if (r_cmd.char_value == glit_pkg::NEWLINE) begin
                                n_desc = 1'b1;
                                n_i    = r_nl;
                            end else begin
                                n_i   = cl_x + NW'(1);
                                n_end = r_nl;
                            end
                        end
                    end
                    glit_pkg::CMD_DEL_BACK: begin
                        clip    = (cnt_x > r_cur) ? r_cur : cnt_x;
                        n_dlt   = clip;
                        n_ref   = r_cur - clip;
                        n_i     = cl_x;
                        n_state = glit_pkg::S_SCAN_RD;
                    end
                    glit_pkg::CMD_DEL_FRONT: begin
                        clip    = (cnt_x > suf) ? suf : cnt_x;
                        n_dlt   = clip;
                        n_ref   = r_cur + clip;
                        n_i     = cl_x + NW'(1);
                        n_state = glit_pkg::S_SCAN_RD;
                    end
                    glit_pkg::CMD_MOVE, glit_pkg::CMD_LOCATE: begin
                        if (off_x > r_len) begin
                            n_st    = glit_pkg::ST_BAD_POS;
                            n_state = glit_pkg::S_DONE;
                        end else begin
                            if (r_cmd.cmd == glit_pkg::CMD_MOVE) begin
                                n_cur = off_x;
                            end
                            n_ref   = off_x;
                            n_lo    = '0;
                            n_hi    = r_nl;
                            n_state = glit_pkg::S_BS_RD;
                        end
                    end
                    glit_pkg::CMD_SPAN: begin
                        if (li_x >= nl_x) begin
                            n_st    = glit_pkg::ST_BAD_POS;
                            n_state = glit_pkg::S_DONE;
                        end else begin
                            ram_raddr = LW'(r_cmd.line_index);
                            n_state   = glit_pkg::S_SPAN_A;
                        end
                    end
                    default: begin
                        n_st    = glit_pkg::ST_BAD_POS;
                        n_state = glit_pkg::S_DONE;
                    end
                endcase
            end
            glit_pkg::S_SCAN_RD: begin
                if (r_cmd.cmd == glit_pkg::CMD_DEL_BACK) begin
                    n_state = (r_i == '0) ? glit_pkg::S_SCAN_END : glit_pkg::S_SCAN_CMP;
                end else begin
                    n_state = (r_i >= r_nl) ? glit_pkg::S_SCAN_END : glit_pkg::S_SCAN_CMP;
                end
            end
            glit_pkg::S_SCAN_CMP: begin
                alu_a   = r_ref;
                alu_b   = ram_rdata;
                alu_sub = 1'b1;
                n_state = glit_pkg::S_SCAN_RD;
                if (r_cmd.cmd == glit_pkg::CMD_DEL_BACK) begin
                    // The new cursor lies before this line start: the line goes away.
                    if (alu_borrow) begin
                        n_del = r_del + NW'(1);
                        n_i   = r_i - NW'(1);
                    end else begin
                        n_state = glit_pkg::S_SCAN_END;
                    end
                end else begin
                    if (!alu_borrow) begin
                        n_del = r_del + NW'(1);
                        n_i   = r_i + NW'(1);
                    end else begin
                        n_state = glit_pkg::S_SCAN_END;
                    end
                end
            end
            glit_pkg::S_SCAN_END: begin
                n_nl    = r_nl - r_del;
                n_end   = r_nl - r_del;
                n_len   = r_len - r_dlt;
                n_state = glit_pkg::S_COPY_RD;
                if (r_cmd.cmd == glit_pkg::CMD_DEL_BACK) begin
                    n_cl  = LW'(cl_x - r_del);
                    n_i   = cl_x - r_del + NW'(1);
                    n_cur = r_cur - r_dlt;
                end else begin
                    n_i = cl_x + NW'(1);
                end
            end
            glit_pkg::S_COPY_RD: begin
                if (r_desc) begin
                    ram_raddr = LW'(r_i - NW'(1));
                    n_state   = (r_i > cl_x + NW'(1)) ? glit_pkg::S_COPY_WR
                                                      : glit_pkg::S_NL_WR;
                end else begin
                    ram_raddr = LW'(r_i + r_del);
                    n_state   = (r_i < r_end) ? glit_pkg::S_COPY_WR : glit_pkg::S_DONE;
                end
            end
            glit_pkg::S_COPY_WR: begin
                ram_we  = 1'b1;
                n_i     = r_desc ? (r_i - NW'(1)) : (r_i + NW'(1));
                n_state = glit_pkg::S_COPY_RD;
            end
            glit_pkg::S_NL_WR: begin
                ram_we    = 1'b1;
                ram_waddr = LW'(cl_x + NW'(1));
                ram_wdata = r_cur;
                n_nl      = r_nl + NW'(1);
                n_cl      = r_cl + LW'(1);
                n_state   = glit_pkg::S_DONE;
            end
            glit_pkg::S_BS_RD: begin
                if (r_lo < r_hi) begin
                    n_i       = mid;
                    ram_raddr = mid[LW-1:0];
                    n_state   = glit_pkg::S_BS_CMP;
                end else if (r_cmd.cmd == glit_pkg::CMD_MOVE) begin
                    n_cl    = LW'(r_lo - NW'(1));
                    n_state = glit_pkg::S_DONE;
                end else begin
                    n_line    = LW'(r_lo - NW'(1));
                    n_found   = 1'b1;
                    ram_raddr = LW'(r_lo - NW'(1));
                    n_state   = glit_pkg::S_COL_CMP;
                end
            end
            glit_pkg::S_BS_CMP: begin
                alu_a   = r_ref;
                alu_b   = ram_rdata;
                alu_sub = 1'b1;
                if (!alu_borrow) begin
                    n_lo = r_i + NW'(1);
                end else begin
                    n_hi = r_i;
                end
                n_state = glit_pkg::S_BS_RD;
            end
            glit_pkg::S_COL_CMP: begin
                alu_a   = r_ref;
                alu_b   = ram_rdata;
                alu_sub = 1'b1;
                n_col   = alu_res;
                n_state = glit_pkg::S_DONE;
            end
            glit_pkg::S_SPAN_A: begin
                n_ss = ram_rdata;
                if (li_x + IW'(1) < nl_x) begin
                    ram_raddr = LW'(r_cmd.line_index + glit_pkg::LINE_W'(1));
                    n_state   = glit_pkg::S_SPAN_B;
                end else begin
                    n_se    = r_len;
                    n_state = glit_pkg::S_DONE;
                end
            end
            glit_pkg::S_SPAN_B: begin
                alu_b   = OW'(1);
                alu_sub = 1'b1;
                n_se    = alu_res;
                n_state = glit_pkg::S_DONE;
            end
            glit_pkg::S_DONE: begin
                if (!r_ovalid || o_res.ready) begin
                    n_out.status      = r_st;
                    n_out.line_number = glit_pkg::LINE_W'(r_found ? r_line : r_cl);
                    n_out.column      = glit_pkg::OFS_W'(r_col);
                    n_out.span_start  = glit_pkg::OFS_W'(r_ss);
                    n_out.span_end    = glit_pkg::OFS_W'(r_se);
                    n_out.text_length = glit_pkg::OFS_W'(r_len);
                    n_ovalid          = 1'b1;
                    n_state           = glit_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = glit_pkg::S_IDLE;
            end
        endcase
    end

    a_lines_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nl != '0 && r_nl <= NW'(LINE_CAP))
        else $error("line count out of range");

    a_cursor_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        NW'(r_cl) < r_nl)
        else $error("cursor line beyond line count");

    a_cursor_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= r_len && r_len <= OW'(TEXT_CAP))
        else $error("cursor beyond text length");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready |=> r_state == glit_pkg::S_START)
        else $error("accepted beat did not start a command");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_res.ready |=> r_ovalid && $stable(r_out))
        else $error("pending result lost");
endmodule
